### hw/rtl/bit_mask_plane_and_pixel_masker_unit_assert.svh
// assertion macros for the mask plane unit
`ifndef BIT_MASK_PLANE_AND_PIXEL_MASKER_UNIT_ASSERT_SVH
`define BIT_MASK_PLANE_AND_PIXEL_MASKER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// property that holds at every edge out of reset
`define BMPM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// condition in one cycle implies a condition in the next
`define BMPM_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define BMPM_ASSERT(lbl, prop, msg)
`define BMPM_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

### hw/rtl/bmpm_pkg.sv
// shared types, codes and a helper function of the mask plane unit
package bmpm_pkg;

  localparam int CMD_W     = 3;
  localparam int COORD_W   = 8;
  localparam int SIZE_W    = 9;
  localparam int PIX_W     = 32;
  localparam int BIDX_W    = 17;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_SET       = 3'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FILL_RECT = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FILL_ALL  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_INVERT    = 3'd5;
  localparam logic [CMD_W-1:0] CMD_APPLY     = 3'd6;
  localparam logic [CMD_W-1:0] CMD_NOP       = 3'd7;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MASK_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_DEPTH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WHITE_VALUE = 2'd3;

  // pixel depth codes
  localparam logic [1:0] DEPTH_1BIT  = 2'd0;
  localparam logic [1:0] DEPTH_8BIT  = 2'd1;
  localparam logic [1:0] DEPTH_24BIT = 2'd2;
  localparam logic [1:0] DEPTH_32BIT = 2'd3;

  // bit packing and fill bytes
  localparam logic [7:0] BIT_MSB   = 8'h80;
  localparam logic [7:0] BYTE_ONES = 8'hFF;

  // register reset values
  localparam logic [8:0] RST_MASK_WIDTH  = 9'd256;
  localparam logic [8:0] RST_MASK_HEIGHT = 9'd256;
  localparam logic [1:0] RST_PIXEL_DEPTH = DEPTH_8BIT;
  localparam logic [7:0] RST_WHITE_VALUE = 8'd255;

  typedef struct packed {
    logic [8:0] mask_width;
    logic [8:0] mask_height;
    logic [1:0] pixel_depth;
    logic [7:0] white_value;
  } cfg_t;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [SIZE_W-1:0]  rect_width;
    logic [SIZE_W-1:0]  rect_height;
    logic               bit_value;
    logic [PIX_W-1:0]   pixel_in;
  } item_t;

  typedef struct packed {
    logic             is_set;
    logic             apply;
    logic [PIX_W-1:0] pixel;
  } res_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } store_ctl_t;

  // replace a masked-out pixel with the white byte as the depth dictates
  function automatic logic [PIX_W-1:0] mask_pixel(input logic [PIX_W-1:0] px,
                                                  input logic keep,
                                                  input logic [1:0] depth,
                                                  input logic [7:0] wv);
    logic [PIX_W-1:0] r;
    r = px;
    if (!keep) begin
      case (depth) inside
        DEPTH_1BIT: r = (wv == 8'd1) ? {px[PIX_W-1:1], 1'b1} : {px[PIX_W-1:1], 1'b0};
        DEPTH_8BIT: r = {px[PIX_W-1:8], wv};
        DEPTH_24BIT, DEPTH_32BIT: r = {px[PIX_W-1:24], wv, wv, wv};
        default: r = px;
      endcase
    end
    return r;
  endfunction

endpackage

### hw/rtl/bmpm_chan_if.sv
// request and result channel interfaces of the mask plane unit
interface bmpm_in_if import bmpm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [COORD_W-1:0] x;
  logic [COORD_W-1:0] y;
  logic [SIZE_W-1:0]  rect_width;
  logic [SIZE_W-1:0]  rect_height;
  logic               bit_value;
  logic [PIX_W-1:0]   pixel_in;

  modport source (output valid, cmd, x, y, rect_width, rect_height, bit_value, pixel_in,
                  input ready);
  modport sink   (input valid, cmd, x, y, rect_width, rect_height, bit_value, pixel_in,
                  output ready);
endinterface

interface bmpm_out_if import bmpm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             is_set;
  logic [PIX_W-1:0] pixel_out;

  modport source (output valid, is_set, pixel_out, input ready);
  modport sink   (input valid, is_set, pixel_out, output ready);
endinterface

### hw/rtl/bmpm_store.sv
// mask byte store: one write port, one registered read port
module bmpm_store import bmpm_pkg::*; #(
  parameter int DEPTH = 8192,
  parameter int AW    = 13
) (
  input  logic          clk,
  input  store_ctl_t    ctl,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered, data held between reads
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hw/rtl/bmpm_seq.sv
// sequencer: address math, read-modify-write of the store, fills and sweeps
`include "bit_mask_plane_and_pixel_masker_unit_assert.svh"
module bmpm_seq import bmpm_pkg::*; #(
  parameter int MAX_WIDTH   = 256,
  parameter int MAX_HEIGHT  = 256,
  parameter int STORE_BYTES = 8192,
  parameter int AW          = 13
) (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  input  item_t         item,
  input  logic          in_valid,
  output logic          in_ready,
  output res_t          res,
  output logic          done,
  input  logic          slot_free,
  output store_ctl_t    store_ctl,
  output logic [AW-1:0] wr_addr,
  output logic [7:0]    wr_data,
  output logic [AW-1:0] rd_addr,
  input  logic [7:0]    rd_data
);

  localparam logic [2:0] S_SWEEP = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_ADDR  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_MOD   = 3'd4;
  localparam logic [2:0] S_RESP  = 3'd5;
  localparam logic [2:0] S_FR_RD = 3'd6;
  localparam logic [2:0] S_FR_WR = 3'd7;

  localparam logic [AW:0] STORE_END = (AW+1)'(STORE_BYTES);

  logic [2:0]        state;
  logic [2:0]        state_next;
  item_t             item_q;

  // sweep control
  logic [AW:0]       sweep_cnt;
  logic [AW:0]       sweep_end;
  logic              sweep_inv;
  logic [7:0]        sweep_val;
  logic              sweep_clr;
  logic              pend_valid;
  logic [AW-1:0]     pend_addr;
  logic              sweep_more;

  // bit walker
  logic [BIDX_W-1:0] cur_b;
  logic [BIDX_W-1:0] row_b;
  logic [8:0]        cur_x;
  logic [8:0]        cur_y;
  logic [8:0]        xe;
  logic [8:0]        ye;
  logic              in_plane;
  logic              res_is_set;

  // combinational helpers
  logic [8:0]        eff_w;
  logic [8:0]        eff_h;
  logic [9:0]        x_sum;
  logic [9:0]        y_sum;
  logic [8:0]        xe_c;
  logic [8:0]        ye_c;
  logic              rect_any;
  logic              rect_last;
  logic [6:0]        wbytes_c;
  logic [15:0]       pbytes_c;
  logic [AW:0]       plane_end_c;
  logic [BIDX_W-1:0] bidx_c;
  logic [AW-1:0]     byte_addr;
  logic [7:0]        bit_mask;
  logic              hit;

  // plane size saturated to the store
  always_comb begin
    eff_w = cfg.mask_width;
    eff_h = cfg.mask_height;
    if (32'(cfg.mask_width) > MAX_WIDTH) begin
      eff_w = 9'(MAX_WIDTH);
    end
    if (32'(cfg.mask_height) > MAX_HEIGHT) begin
      eff_h = 9'(MAX_HEIGHT);
    end
  end

  // rectangle clipping and plane byte count
  always_comb begin
    x_sum       = 10'(item_q.x) + 10'(item_q.rect_width);
    y_sum       = 10'(item_q.y) + 10'(item_q.rect_height);
    xe_c        = (x_sum > 10'(eff_w)) ? eff_w : x_sum[8:0];
    ye_c        = (y_sum > 10'(eff_h)) ? eff_h : y_sum[8:0];
    rect_any    = (9'(item_q.x) < xe_c) && (9'(item_q.y) < ye_c);
    wbytes_c    = 7'((10'(eff_w) + 10'd7) >> 3);
    pbytes_c    = 16'(wbytes_c) * 16'(eff_h);
    plane_end_c = (AW+1)'(pbytes_c);
    bidx_c      = BIDX_W'(eff_w) * BIDX_W'(item_q.y) + BIDX_W'(item_q.x);
  end

  // byte address and bit lane of the current bit
  assign byte_addr  = AW'(cur_b >> 3);
  assign bit_mask   = BIT_MSB >> cur_b[2:0];
  assign hit        = |(rd_data & bit_mask);
  assign sweep_more = sweep_cnt < sweep_end;
  assign rect_last  = (cur_x + 9'd1 >= xe) && (cur_y + 9'd1 >= ye);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_SWEEP: begin
        if (!sweep_more && !pend_valid) begin
          state_next = sweep_clr ? S_IDLE : S_RESP;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_ADDR;
        end
      end
      S_ADDR: begin
        unique case (item_q.cmd) inside
          CMD_SET, CMD_CLEAR, CMD_QUERY, CMD_APPLY: state_next = S_READ;
          CMD_FILL_RECT: state_next = rect_any ? S_FR_RD : S_RESP;
          CMD_FILL_ALL, CMD_INVERT: state_next = S_SWEEP;
          default: state_next = S_RESP;
        endcase
      end
      S_READ:  state_next = S_MOD;
      S_MOD:   state_next = S_RESP;
      S_RESP: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      S_FR_RD: state_next = S_FR_WR;
      S_FR_WR: state_next = rect_last ? S_RESP : S_FR_RD;
    endcase
  end

  // store port drive
  always_comb begin
    store_ctl = '0;
    wr_addr   = byte_addr;
    rd_addr   = byte_addr;
    wr_data   = rd_data;
    case (state)
      S_SWEEP: begin
        if (sweep_more) begin
          if (sweep_inv) begin
            store_ctl.rd_en = 1'b1;
            rd_addr         = sweep_cnt[AW-1:0];
          end else begin
            store_ctl.wr_en = 1'b1;
            wr_addr         = sweep_cnt[AW-1:0];
            wr_data         = sweep_val;
          end
        end
        if (pend_valid) begin
          store_ctl.wr_en = 1'b1;
          wr_addr         = pend_addr;
          wr_data         = ~rd_data;
        end
      end
      S_READ:  store_ctl.rd_en = in_plane;
      S_FR_RD: store_ctl.rd_en = 1'b1;
      S_MOD: begin
        if (in_plane && (item_q.cmd == CMD_SET || item_q.cmd == CMD_CLEAR)) begin
          store_ctl.wr_en = 1'b1;
          wr_data = (item_q.cmd == CMD_SET) ? (rd_data | bit_mask) : (rd_data & ~bit_mask);
        end
      end
      S_FR_WR: begin
        store_ctl.wr_en = 1'b1;
        wr_data = item_q.bit_value ? (rd_data | bit_mask) : (rd_data & ~bit_mask);
      end
      default: ;
    endcase
  end

  // control state; reset starts the clearing pass over the whole store
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_SWEEP;
      sweep_cnt  <= '0;
      sweep_end  <= STORE_END;
      sweep_inv  <= 1'b0;
      sweep_val  <= '0;
      sweep_clr  <= 1'b1;
      pend_valid <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_SWEEP: begin
          if (sweep_more) begin
            sweep_cnt  <= sweep_cnt + 1'b1;
            pend_valid <= sweep_inv;
          end else begin
            pend_valid <= 1'b0;
          end
        end
        S_ADDR: begin
          sweep_cnt  <= '0;
          sweep_end  <= plane_end_c;
          sweep_inv  <= (item_q.cmd == CMD_INVERT);
          sweep_val  <= item_q.bit_value ? BYTE_ONES : 8'h00;
          sweep_clr  <= 1'b0;
          pend_valid <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // request payload and bit walker
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_q <= item;
    end
    case (state)
      S_SWEEP: pend_addr <= sweep_cnt[AW-1:0];
      S_ADDR: begin
        cur_b      <= bidx_c;
        row_b      <= bidx_c;
        cur_x      <= 9'(item_q.x);
        cur_y      <= 9'(item_q.y);
        xe         <= xe_c;
        ye         <= ye_c;
        in_plane   <= (9'(item_q.x) < eff_w) && (9'(item_q.y) < eff_h);
        res_is_set <= 1'b0;
      end
      S_MOD: begin
        res_is_set <= in_plane && hit &&
                      (item_q.cmd == CMD_QUERY || item_q.cmd == CMD_APPLY);
      end
      S_FR_WR: begin
        if (cur_x + 9'd1 < xe) begin
          cur_x <= cur_x + 9'd1;
          cur_b <= cur_b + 1'b1;
        end else begin
          cur_x <= 9'(item_q.x);
          cur_y <= cur_y + 9'd1;
          row_b <= row_b + BIDX_W'(eff_w);
          cur_b <= row_b + BIDX_W'(eff_w);
        end
      end
      default: ;
    endcase
  end

  assign in_ready   = (state == S_IDLE);
  assign done       = (state == S_RESP);
  assign res.is_set = res_is_set;
  assign res.apply  = (item_q.cmd == CMD_APPLY);
  assign res.pixel  = item_q.pixel_in;

  `BMPM_ASSERT(a_no_rw_clash, !(store_ctl.wr_en && store_ctl.rd_en && wr_addr == rd_addr), "read and write hit the same byte in one cycle")
  `BMPM_ASSERT(a_wr_in_store, !store_ctl.wr_en || ((AW+1)'(wr_addr) < STORE_END), "write beyond the store")
  `BMPM_ASSERT(a_sweep_bound, state != S_SWEEP || sweep_cnt <= sweep_end, "sweep ran past its end")
  `BMPM_ASSERT_NEXT(a_accept_addr, in_valid && in_ready, state == S_ADDR, "accepted request not decoded")

endmodule

### hw/rtl/bit_mask_plane_and_pixel_masker_unit.sv
// Mask plane unit: set, clear and query bits, rectangle and plane fills, invert, pixel masking.
// Bit requests (set, clear, query, apply) pass the ADDR, READ and MOD states to RESP, one at a time.
// Fill rect rewrites the byte of each covered bit, fill all writes and invert flips each plane byte;
// the result is valid in the same cycle that the next request can be taken.
// Reset is synchronous; after it a clearing pass writes all STORE_BYTES bytes (8192 by default),
// one per cycle, and no request is accepted until it ends; configuration writes are taken at once.
`include "bit_mask_plane_and_pixel_masker_unit_assert.svh"
module bit_mask_plane_and_pixel_masker_unit import bmpm_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  bmpm_in_if.sink              in_ch,
  bmpm_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int STORE_BYTES = ((MAX_WIDTH + 7) / 8) * MAX_HEIGHT;
  localparam int AW          = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

  cfg_t             cfg;
  item_t            item;
  res_t             res;
  logic             done;
  logic             slot_free;
  logic             seq_ready;
  store_ctl_t       store_ctl;
  logic [AW-1:0]    wr_addr;
  logic [AW-1:0]    rd_addr;
  logic [7:0]       wr_data;
  logic [7:0]       rd_data;
  logic             out_valid;
  logic             out_is_set;
  logic [PIX_W-1:0] out_pixel;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mask_width  <= RST_MASK_WIDTH;
      cfg.mask_height <= RST_MASK_HEIGHT;
      cfg.pixel_depth <= RST_PIXEL_DEPTH;
      cfg.white_value <= RST_WHITE_VALUE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MASK_WIDTH:  cfg.mask_width  <= cfg_data;
        REG_MASK_HEIGHT: cfg.mask_height <= cfg_data;
        REG_PIXEL_DEPTH: cfg.pixel_depth <= cfg_data[1:0];
        REG_WHITE_VALUE: cfg.white_value <= cfg_data[7:0];
      endcase
    end
  end

  // request payload into the sequencer
  always_comb begin
    item.cmd         = in_ch.cmd;
    item.x           = in_ch.x;
    item.y           = in_ch.y;
    item.rect_width  = in_ch.rect_width;
    item.rect_height = in_ch.rect_height;
    item.bit_value   = in_ch.bit_value;
    item.pixel_in    = in_ch.pixel_in;
  end

  assign in_ch.ready = seq_ready;

  bmpm_seq #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .STORE_BYTES(STORE_BYTES),
    .AW         (AW)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .item     (item),
    .in_valid (in_ch.valid),
    .in_ready (seq_ready),
    .res      (res),
    .done     (done),
    .slot_free(slot_free),
    .store_ctl(store_ctl),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data)
  );

  bmpm_store #(
    .DEPTH(STORE_BYTES),
    .AW   (AW)
  ) u_store (
    .clk    (clk),
    .ctl    (store_ctl),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // output register
  assign slot_free = !out_valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done && slot_free) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  // result payload with pixel masking
  always_ff @(posedge clk) begin
    if (done && slot_free) begin
      out_is_set <= res.is_set;
      out_pixel  <= res.apply ?
                    mask_pixel(res.pixel, res.is_set, cfg.pixel_depth, cfg.white_value) : '0;
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.is_set    = out_is_set;
  assign out_ch.pixel_out = out_pixel;

  `BMPM_ASSERT_NEXT(a_res_held, done && !slot_free, done, "finished result dropped while output full")
  `BMPM_ASSERT(a_ready_not_done, !(in_ch.ready && done), "request taken while a result waits")
  `BMPM_ASSERT_NEXT(a_load_out, done && slot_free, out_ch.valid, "finished result not registered")

endmodule
